[rtl/bba_pkg.sv]
// shared types and constants of the bitmap block allocator
package bba_pkg;

    localparam int WORD_BITS      = 64;
    localparam int BIT_W          = $clog2(WORD_BITS);
    localparam int NUM_BLOCKS_DEF = 4096;
    localparam int IDX_W          = 12;
    localparam int CNT_W          = 13;

    typedef enum logic
    {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_ALLOC = 2'd2
    } status_t;

    typedef struct packed
    {
        logic wr;
        logic full;
    } summ_upd_t;

endpackage

[rtl/bba_ifs.sv]
// request and response channels of the bitmap block allocator
interface bba_req_if;
    logic                         valid;
    logic                         ready;
    bba_pkg::cmd_t                cmd;
    logic [bba_pkg::IDX_W-1:0]    block_index;

    modport source (output valid, output cmd, output block_index, input ready);
    modport sink   (input valid, input cmd, input block_index, output ready);
endinterface

interface bba_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bba_pkg::IDX_W-1:0]    block_index_out;
    bba_pkg::status_t             status;
    logic [bba_pkg::CNT_W-1:0]    used_count;

    modport source (output valid, output block_index_out, output status,
                    output used_count, input ready);
    modport sink   (input valid, input block_index_out, input status,
                    input used_count, output ready);
endinterface

[rtl/bitmap_block_allocator.sv]
// First-fit bitmap block allocator, top level.
// req carries one word per request: cmd (allocate or free) and block_index
// (the block to free, ignored on allocate). rsp returns one word per
// request: block_index_out (allocated or echoed index), status (ok, full,
// not allocated) and used_count after the request.
// The used bitmap sits in one ram of WORD_BITS-bit words; a flag per word
// marks full words, and the lowest non-full word is picked in the accept
// cycle, so the ram read goes out at once.
// A request is accepted in S_IDLE while the ram read goes out; in S_LOOK
// the read word is modified and, once rsp is free, written back while the
// response register is loaded; req.ready stays low until then.
// A request is taken while an earlier response still waits in the output
// register; it then holds before its write-back until rsp is free.
// After reset the ram is cleared one word per cycle, all NUM_BLOCKS/WORD_BITS
// words (rounded up), and req.ready stays low until that pass is over.
// Failed requests (full, free of an unused or out-of-range block) leave the
// bitmap and the count unchanged.
module bitmap_block_allocator #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    bba_req_if.sink   req,
    bba_rsp_if.source rsp
);
    import bba_pkg::*;

    localparam int NUM_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int EXT_W     = WIDX_W + BIT_W;
    localparam int WIDE_W    = EXT_W + IDX_W;
    localparam int LAST_BITS = NUM_BLOCKS - (NUM_WORDS - 1) * WORD_BITS;
    localparam int LIM_W     = 17;
    localparam logic [LIM_W-1:0] BLK_LIMIT = LIM_W'(NUM_BLOCKS);
    localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(NUM_WORDS - 1);
    localparam logic [WORD_BITS-1:0] PAD_MASK = (LAST_BITS >= WORD_BITS) ? '0 :
        ~((WORD_BITS'(1) << LAST_BITS) - WORD_BITS'(1));

    typedef enum logic [2:0]
    {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } state_t;

    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                r = BIT_W'(i);
            end
        end
        return r;
    endfunction

    state_t             state_reg, state_next;
    logic [WIDX_W-1:0]  clr_addr_reg, clr_addr_next;
    cmd_t               cmd_reg, cmd_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [WIDX_W-1:0]  word_reg, word_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic               miss_reg, miss_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]   out_idx_reg, out_idx_next;
    status_t            out_status_reg, out_status_next;
    logic [CNT_W-1:0]   out_count_reg, out_count_next;

    logic               accept;
    logic               commit;
    logic [WIDE_W-1:0]  idx_wide;
    logic [WIDX_W-1:0]  req_word;
    logic               in_range;
    logic [WIDX_W-1:0]  free_word;
    logic               all_full;
    logic [WORD_BITS-1:0] rdata;
    logic [WORD_BITS-1:0] pad_word;
    logic [BIT_W-1:0]   alloc_bit;
    logic [WORD_BITS-1:0] set_word;
    logic [WORD_BITS-1:0] clr_word;
    logic               bit_set;
    logic               ok;
    logic [WIDE_W-1:0]  alloc_wide;
    logic               ram_we;
    logic [WIDX_W-1:0]  ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    summ_upd_t          summ_upd;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    assign idx_wide = WIDE_W'(req.block_index);
    assign in_range = (LIM_W'(req.block_index) < BLK_LIMIT);
    assign req_word = (req.cmd == CMD_ALLOC) ? free_word : idx_wide[EXT_W-1:BIT_W];

    assign commit = (state_reg == S_LOOK) && (!out_valid_reg || rsp.ready);

    assign pad_word   = rdata | ((word_reg == LAST_WORD) ? PAD_MASK : '0);
    assign alloc_bit  = lowest_zero(pad_word);
    assign set_word   = rdata | (WORD_BITS'(1) << alloc_bit);
    assign clr_word   = rdata & ~(WORD_BITS'(1) << bit_reg);
    assign bit_set    = rdata[bit_reg];
    assign ok         = (cmd_reg == CMD_ALLOC) ? !miss_reg : (!miss_reg && bit_set);
    assign alloc_wide = WIDE_W'({word_reg, alloc_bit});

    assign ram_we    = (state_reg == S_CLEAR) || (commit && ok);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_addr_reg : word_reg;
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 :
                       ((cmd_reg == CMD_ALLOC) ? set_word : clr_word);

    assign summ_upd.wr   = commit && ok;
    assign summ_upd.full = (cmd_reg == CMD_ALLOC) ? &(set_word | pad_word) : 1'b0;

    bba_ram #(
        .WIDTH  (WORD_BITS),
        .DEPTH  (NUM_WORDS),
        .ADDR_W (WIDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (req_word),
        .rdata (rdata)
    );

    bba_summary #(
        .NUM_WORDS (NUM_WORDS),
        .WIDX_W    (WIDX_W)
    ) u_summary (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (summ_upd),
        .upd_addr  (word_reg),
        .free_word (free_word),
        .all_full  (all_full)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        word_next       = word_reg;
        bit_next        = bit_reg;
        miss_next       = miss_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        out_idx_next    = out_idx_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + WIDX_W'(1);
                if (clr_addr_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = req.cmd;
                    idx_next   = req.block_index;
                    word_next  = req_word;
                    bit_next   = idx_wide[BIT_W-1:0];
                    miss_next  = (req.cmd == CMD_ALLOC) ? all_full : !in_range;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (commit)
                begin
                    if (ok)
                    begin
                        count_next = (cmd_reg == CMD_ALLOC) ? count_reg + CNT_W'(1)
                                                            : count_reg - CNT_W'(1);
                    end
                    out_valid_next = 1'b1;
                    out_count_next = count_next;
                    if (cmd_reg == CMD_ALLOC)
                    begin
                        out_idx_next    = miss_reg ? '0 : alloc_wide[IDX_W-1:0];
                        out_status_next = miss_reg ? STATUS_FULL : STATUS_OK;
                    end
                    else
                    begin
                        out_idx_next    = idx_reg;
                        out_status_next = ok ? STATUS_OK : STATUS_NOT_ALLOC;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        idx_reg        <= idx_next;
        word_reg       <= word_next;
        bit_reg        <= bit_next;
        miss_reg       <= miss_next;
        out_idx_reg    <= out_idx_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.block_index_out = out_idx_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.used_count      = out_count_reg;

endmodule

[rtl/bba_ram.sv]
// generic single-port-write, registered-read ram
module bba_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bba_summary.sv]
// full-word summary flags and lowest non-full word search
module bba_summary #(
    parameter int NUM_WORDS = 64,
    parameter int WIDX_W    = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bba_pkg::summ_upd_t   upd,
    input  logic [WIDX_W-1:0]    upd_addr,
    output logic [WIDX_W-1:0]    free_word,
    output logic                 all_full
);
    import bba_pkg::*;

    logic [NUM_WORDS-1:0] full_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= '0;
        end
        else if (upd.wr)
        begin
            full_reg[upd_addr] <= upd.full;
        end
    end

    always_comb
    begin
        free_word = '0;
        for (int i = NUM_WORDS - 1; i >= 0; i--)
        begin
            if (!full_reg[i])
            begin
                free_word = WIDX_W'(i);
            end
        end
    end

    assign all_full = &full_reg;

endmodule

[test/tb_bitmap_block_allocator.sv]
// testbench for the first-fit bitmap block allocator: directed table, random words, scoreboard
`timescale 1ns / 100ps

module tb_bitmap_block_allocator;
    import bba_pkg::*;

    localparam int NUM_WORDS    = NUM_BLOCKS_DEF / WORD_BITS;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed
    {
        logic [IDX_W-1:0] idx;
        status_t          st;
        logic [CNT_W-1:0] cnt;
    } rsp_word_t;

    typedef struct packed
    {
        cmd_t             cmd;
        logic [IDX_W-1:0] idx;
        logic             typed;
        rsp_word_t        want;
    } dir_row_t;

    localparam int DIR_ROWS = 24;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{CMD_ALLOC, 12'h000, 1'b1, '{12'h000, STATUS_OK,        13'd1}},
        '{CMD_ALLOC, 12'hfff, 1'b1, '{12'h001, STATUS_OK,        13'd2}},
        '{CMD_FREE,  12'hfff, 1'b1, '{12'hfff, STATUS_NOT_ALLOC, 13'd2}},
        '{CMD_FREE,  12'h000, 1'b1, '{12'h000, STATUS_OK,        13'd1}},
        '{CMD_FREE,  12'h000, 1'b1, '{12'h000, STATUS_NOT_ALLOC, 13'd1}},
        '{CMD_ALLOC, 12'h000, 1'b1, '{12'h000, STATUS_OK,        13'd2}},
        '{CMD_ALLOC, 12'h555, 1'b1, '{12'h002, STATUS_OK,        13'd3}},
        '{CMD_FREE,  12'h001, 1'b1, '{12'h001, STATUS_OK,        13'd2}},
        '{CMD_ALLOC, 12'haaa, 1'b1, '{12'h001, STATUS_OK,        13'd3}},
        '{CMD_FREE,  12'h800, 1'b1, '{12'h800, STATUS_NOT_ALLOC, 13'd3}},
        '{CMD_FREE,  12'h03f, 1'b1, '{12'h03f, STATUS_NOT_ALLOC, 13'd3}},
        '{CMD_FREE,  12'h002, 1'b1, '{12'h002, STATUS_OK,        13'd2}},
        '{CMD_FREE,  12'h002, 1'b1, '{12'h002, STATUS_NOT_ALLOC, 13'd2}},
        '{CMD_ALLOC, 12'h000, 1'b1, '{12'h002, STATUS_OK,        13'd3}},
        '{CMD_ALLOC, 12'h7ff, 1'b0, '0},
        '{CMD_ALLOC, 12'h123, 1'b0, '0},
        '{CMD_FREE,  12'h001, 1'b0, '0},
        '{CMD_FREE,  12'h004, 1'b0, '0},
        '{CMD_ALLOC, 12'hfff, 1'b0, '0},
        '{CMD_FREE,  12'h000, 1'b0, '0},
        '{CMD_FREE,  12'h003, 1'b0, '0},
        '{CMD_FREE,  12'h002, 1'b0, '0},
        '{CMD_FREE,  12'h003, 1'b0, '0},
        '{CMD_ALLOC, 12'h000, 1'b0, '0}
    };

    logic clk;
    logic rst_n;

    bba_req_if req_ch ();
    bba_rsp_if rsp_ch ();

    bitmap_block_allocator DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [WORD_BITS-1:0] used_map [NUM_WORDS];
    logic [CNT_W-1:0]     used_cnt;
    rsp_word_t            pending_rsp [$];
    int                   fail_count;
    int                   send_idle_pct;
    int                   rsp_stall_pct;
    bit                   hold_rsp_req;

    function automatic rsp_word_t predict_alloc_free(cmd_t c, logic [IDX_W-1:0] i);
        rsp_word_t w;
        bit        found;
        w.idx = '0;
        w.st  = STATUS_OK;
        found = 1'b0;
        if (c == CMD_ALLOC)
        begin
            for (int wi = 0; wi < NUM_WORDS && !found; wi++)
            begin
                if (used_map[wi] != '1)
                begin
                    for (int bi = 0; bi < WORD_BITS && !found; bi++)
                    begin
                        if (!used_map[wi][bi])
                        begin
                            found            = 1'b1;
                            used_map[wi][bi] = 1'b1;
                            used_cnt         = used_cnt + 1'b1;
                            w.idx            = IDX_W'(wi * WORD_BITS + bi);
                        end
                    end
                end
            end
            if (!found)
                w.st = STATUS_FULL;
        end
        else
        begin
            w.idx = i;
            if (used_map[i[IDX_W-1:BIT_W]][i[BIT_W-1:0]])
            begin
                used_map[i[IDX_W-1:BIT_W]][i[BIT_W-1:0]] = 1'b0;
                used_cnt = used_cnt - 1'b1;
            end
            else
                w.st = STATUS_NOT_ALLOC;
        end
        w.cnt = used_cnt;
        return w;
    endfunction

    // nearest used block at or above start, wrapping round
    function automatic logic [IDX_W-1:0] used_block_near(int start);
        int j;
        for (int k = 0; k < NUM_BLOCKS_DEF; k++)
        begin
            j = (start + k) % NUM_BLOCKS_DEF;
            if (used_map[j / WORD_BITS][j % WORD_BITS])
                return IDX_W'(j);
        end
        return IDX_W'(start);
    endfunction

    task automatic put_req(cmd_t c, logic [IDX_W-1:0] i, logic typed, rsp_word_t want);
        rsp_word_t w;
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid       <= 1'b0;
            req_ch.cmd         <= cmd_t'($urandom_range(0, 1));
            req_ch.block_index <= IDX_W'($urandom);
            @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= c;
        req_ch.block_index <= i;
        do
            @(posedge clk);
        while (!req_ch.ready);
        w = predict_alloc_free(c, i);
        pending_rsp.push_back(typed ? want : w);
    endtask

    task automatic rand_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            put_req(CMD_ALLOC, IDX_W'($urandom), 1'b0, '0);
        else if (r < 85 && used_cnt != 0)
            put_req(CMD_FREE, used_block_near($urandom_range(0, NUM_BLOCKS_DEF - 1)), 1'b0, '0);
        else
            put_req(CMD_FREE, IDX_W'($urandom), 1'b0, '0);
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // response side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_rsp_req)
            begin
                hold_rsp_req = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= (rsp_stall_pct == 0) || ($urandom_range(0, 99) >= rsp_stall_pct);
        end
    end

    // scoreboard
    initial
    begin
        rsp_word_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $error("unexpected response word: block_index_out %0d status %0d",
                           rsp_ch.block_index_out, rsp_ch.status);
                    fail_count++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp_ch.block_index_out !== want.idx)
                    begin
                        $error("block_index_out: expected %0d, got %0d",
                               want.idx, rsp_ch.block_index_out);
                        fail_count++;
                    end
                    if (rsp_ch.status !== want.st)
                    begin
                        $error("status: expected %0d, got %0d", want.st, rsp_ch.status);
                        fail_count++;
                    end
                    if (rsp_ch.used_count !== want.cnt)
                    begin
                        $error("used_count: expected %0d, got %0d",
                               want.cnt, rsp_ch.used_count);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("bitmap_block_allocator test failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.cmd         = CMD_ALLOC;
        req_ch.block_index = '0;
        fail_count         = 0;
        send_idle_pct      = 0;
        rsp_stall_pct      = 0;
        hold_rsp_req       = 1'b0;
        used_cnt           = '0;
        for (int k = 0; k < NUM_WORDS; k++)
            used_map[k] = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int k = 0; k < DIR_ROWS; k++)
            put_req(dir_rows[k].cmd, dir_rows[k].idx, dir_rows[k].typed, dir_rows[k].want);

        send_idle_pct = 52;
        rsp_stall_pct = 0;
        repeat (300) rand_word();

        send_idle_pct = 0;
        rsp_stall_pct = 52;
        hold_rsp_req  = 1'b1;
        repeat (300) rand_word();

        send_idle_pct = 38;
        rsp_stall_pct = 38;
        repeat (300) rand_word();

        // free scattered used blocks, then reuse the holes
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        repeat (120)
            put_req(CMD_FREE, used_block_near($urandom_range(0, NUM_BLOCKS_DEF - 1)),
                    1'b0, '0);
        repeat (125) put_req(CMD_ALLOC, IDX_W'($urandom), 1'b0, '0);
        repeat (80) rand_word();

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("bitmap_block_allocator test passed");
        else
            $display("bitmap_block_allocator test failed");
        $finish;
    end

endmodule
